// ===== rtl/mrr_pkg.sv =====
// Shared types, codes and the CRC-16 byte update of the Modbus RTU read master.
`default_nettype none
package mrr_pkg;

  localparam int unsigned MAX_RESPONSE_LEN_DEF = 256;
  localparam int unsigned LEN_W = 9;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;

  localparam logic [2:0] CRC_LOW_BEAT  = 3'd6;
  localparam logic [2:0] FINAL_BEAT    = 3'd7;

  typedef enum logic [1:0] {
    MODE_REQ   = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_FETCH = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_REJECT  = 2'd1,
    KIND_VERDICT = 2'd2,
    KIND_FETCH   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BUSY      = 3'd1,
    STAT_BAD_COUNT = 3'd2,
    STAT_CRC_ERR   = 3'd3,
    STAT_NOT_READY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WAIT  = 2'd1,
    ST_READY = 2'd2,
    ST_ERROR = 2'd3
  } mstate_t;

  // One result set handed from the controller to the transmit stage.
  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [15:0] value;
    mstate_t     mstate;
    logic [7:0]  addr;
    logic [15:0] first;
    logic [15:0] count;
  } load_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/modbus_rtu_read_register_master.sv =====
// Top level of the Modbus RTU master for reading holding registers.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | input     | in_tvalid/in_tready  | in_tdata (fields), in_tuser (mode)
//  out_    | output    | out_tvalid/out_tready| out_tdata (fields), out_tuser (kind), out_tlast
//
// Each input beat is registered, processed and, if it has results, loaded into the
// result stage, whose register then offers the first result beat.
// Beats without results are taken every cycle; a beat with results waits while the result
// stage is busy, so a request that is sent holds the next such beat for eight output beats.
// The reset is synchronous and active low and puts the master in the idle state.
// A stalled output holds the input register only when the waiting beat has results.
`default_nettype none
module modbus_rtu_read_register_master #(
  parameter int unsigned MAX_RESPONSE_LEN = mrr_pkg::MAX_RESPONSE_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // slave_address [7:0], first_register [23:8], register_count [39:24], rx_byte [47:40]
  input  wire logic [47:0] in_tdata,
  // mode [1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tx_byte [7:0], status [10:8], register_value [26:11], master_state [28:27]
  output logic [31:0]      out_tdata,
  // kind [1:0]
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  logic            ld_valid;
  logic            ld_ok;
  mrr_pkg::load_t  ld;

  mrr_ctrl #(
    .MAX_RESPONSE_LEN(MAX_RESPONSE_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .ld_valid  (ld_valid),
    .ld        (ld),
    .ld_ok     (ld_ok)
  );

  mrr_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_valid   (ld_valid),
    .ld         (ld),
    .ld_ok      (ld_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== rtl/mrr_tx.sv =====
// Result stage: holds one result set and drives it out, serialising request frames.
`default_nettype none
module mrr_tx (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          ld_valid,
  input  wire mrr_pkg::load_t ld,
  output logic               ld_ok,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [31:0]        out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);

  logic                 valid_r;
  logic [2:0]           beat_r;
  mrr_pkg::kind_t       kind_r;
  mrr_pkg::status_t     status_r;
  logic [15:0]          value_r;
  mrr_pkg::mstate_t     mstate_r;
  logic [47:0]          shift_r;
  logic [15:0]          crc_r;

  logic                 is_tx;
  logic                 done;
  logic [7:0]           tx_byte;

  assign is_tx = (kind_r == mrr_pkg::KIND_TX);
  assign done  = valid_r && out_tready && (!is_tx || (beat_r == mrr_pkg::FINAL_BEAT));
  assign ld_ok = !valid_r || done;

  always_comb begin
    if (!is_tx) begin
      tx_byte = 8'h00;
    end else if (beat_r < mrr_pkg::CRC_LOW_BEAT) begin
      tx_byte = shift_r[7:0];
    end else if (beat_r == mrr_pkg::CRC_LOW_BEAT) begin
      tx_byte = crc_r[7:0];
    end else begin
      tx_byte = crc_r[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= 3'd0;
    end else if (ld_valid && ld_ok) begin
      valid_r <= 1'b1;
      beat_r  <= 3'd0;
    end else if (done) begin
      valid_r <= 1'b0;
    end else if (valid_r && out_tready) begin
      beat_r <= beat_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid && ld_ok) begin
      kind_r   <= ld.kind;
      status_r <= ld.status;
      value_r  <= ld.value;
      mstate_r <= ld.mstate;
      shift_r  <= {ld.count[7:0], ld.count[15:8], ld.first[7:0], ld.first[15:8],
                   mrr_pkg::FUNC_READ_HOLDING, ld.addr};
      crc_r    <= mrr_pkg::CRC_INIT;
    end else if (valid_r && out_tready && is_tx && (beat_r < mrr_pkg::CRC_LOW_BEAT)) begin
      crc_r   <= mrr_pkg::crc_byte(crc_r, shift_r[7:0]);
      shift_r <= {8'h00, shift_r[47:8]};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = is_tx && (beat_r == mrr_pkg::FINAL_BEAT);
  assign out_tdata  = {3'b000, mstate_r, value_r, status_r, tx_byte};

endmodule
`default_nettype wire

// ===== rtl/mrr_ctrl.sv =====
// Input register and master state: request checks, response CRC and value capture.
`default_nettype none
module mrr_ctrl #(
  parameter int unsigned MAX_RESPONSE_LEN = mrr_pkg::MAX_RESPONSE_LEN_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [47:0]    in_tdata,
  input  wire logic [1:0]     in_tuser,
  output logic                ld_valid,
  output mrr_pkg::load_t      ld,
  input  wire logic           ld_ok
);

  localparam int unsigned LW = mrr_pkg::LEN_W;

  logic                 in_valid_r;
  mrr_pkg::mode_t       mode_r;
  logic [7:0]           addr_r;
  logic [15:0]          first_r;
  logic [15:0]          count_r;
  logic [7:0]           rx_r;

  mrr_pkg::mstate_t     state_r, state_nxt;
  logic [LW-1:0]        exp_len_r, exp_len_nxt;
  logic [LW-1:0]        idx_r, idx_nxt;
  logic [15:0]          crc_r, crc_nxt;
  logic [7:0]           crc_low_r, crc_low_nxt;
  logic [7:0]           vhigh_r, vhigh_nxt;
  logic [15:0]          value_r, value_nxt;

  logic                 has_result;
  logic                 advance;
  logic [17:0]          need;
  logic [LW:0]          idx_p2;

  assign need    = 18'd5 + {1'b0, count_r, 1'b0};
  assign idx_p2  = {1'b0, idx_r} + (LW+1)'(2);
  assign advance = in_valid_r && (!has_result || ld_ok);
  assign in_tready = !in_valid_r || advance;
  assign ld_valid  = in_valid_r && has_result && ld_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      mode_r  <= mrr_pkg::mode_t'(in_tuser);
      addr_r  <= in_tdata[7:0];
      first_r <= in_tdata[23:8];
      count_r <= in_tdata[39:24];
      rx_r    <= in_tdata[47:40];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mrr_pkg::ST_IDLE;
      exp_len_r <= '0;
      idx_r     <= '0;
      crc_r     <= mrr_pkg::CRC_INIT;
      crc_low_r <= 8'h00;
      vhigh_r   <= 8'h00;
      value_r   <= 16'h0000;
    end else if (advance) begin
      state_r   <= state_nxt;
      exp_len_r <= exp_len_nxt;
      idx_r     <= idx_nxt;
      crc_r     <= crc_nxt;
      crc_low_r <= crc_low_nxt;
      vhigh_r   <= vhigh_nxt;
      value_r   <= value_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    exp_len_nxt = exp_len_r;
    idx_nxt     = idx_r;
    crc_nxt     = crc_r;
    crc_low_nxt = crc_low_r;
    vhigh_nxt   = vhigh_r;
    value_nxt   = value_r;
    has_result  = 1'b0;
    ld.kind     = mrr_pkg::KIND_TX;
    ld.status   = mrr_pkg::STAT_OK;
    ld.value    = 16'h0000;
    ld.mstate   = state_r;
    ld.addr     = addr_r;
    ld.first    = first_r;
    ld.count    = count_r;
    case (mode_r)
      mrr_pkg::MODE_REQ: begin
        has_result = 1'b1;
        if (state_r == mrr_pkg::ST_WAIT) begin
          ld.kind   = mrr_pkg::KIND_REJECT;
          ld.status = mrr_pkg::STAT_BUSY;
        end else if ((count_r == 16'h0000) || (need > 18'(MAX_RESPONSE_LEN))) begin
          ld.kind   = mrr_pkg::KIND_REJECT;
          ld.status = mrr_pkg::STAT_BAD_COUNT;
        end else begin
          state_nxt   = mrr_pkg::ST_WAIT;
          exp_len_nxt = need[LW-1:0];
          idx_nxt     = '0;
          crc_nxt     = mrr_pkg::CRC_INIT;
          ld.mstate   = mrr_pkg::ST_WAIT;
        end
      end
      mrr_pkg::MODE_BYTE: begin
        if (state_r == mrr_pkg::ST_WAIT) begin
          idx_nxt = idx_r + LW'(1);
          if (idx_p2 < {1'b0, exp_len_r}) begin
            crc_nxt = mrr_pkg::crc_byte(crc_r, rx_r);
            if (idx_r == LW'(3)) begin
              vhigh_nxt = rx_r;
            end else if (idx_r == LW'(4)) begin
              value_nxt = {vhigh_r, rx_r};
            end
          end else if (idx_p2 == {1'b0, exp_len_r}) begin
            crc_low_nxt = rx_r;
          end else begin
            has_result = 1'b1;
            ld.kind    = mrr_pkg::KIND_VERDICT;
            if ({rx_r, crc_low_r} == crc_r) begin
              state_nxt = mrr_pkg::ST_READY;
              ld.mstate = mrr_pkg::ST_READY;
            end else begin
              state_nxt = mrr_pkg::ST_ERROR;
              ld.mstate = mrr_pkg::ST_ERROR;
              ld.status = mrr_pkg::STAT_CRC_ERR;
            end
          end
        end
      end
      mrr_pkg::MODE_FETCH: begin
        has_result = 1'b1;
        ld.kind    = mrr_pkg::KIND_FETCH;
        if (state_r == mrr_pkg::ST_READY) begin
          state_nxt = mrr_pkg::ST_IDLE;
          ld.mstate = mrr_pkg::ST_IDLE;
          ld.value  = value_r;
        end else begin
          ld.status = mrr_pkg::STAT_NOT_READY;
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the Modbus RTU holding-register read master.
module tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  addr;
    logic [15:0] first;
    logic [15:0] count;
    logic [7:0]  rx;
  } beat_t;

  typedef struct packed {
    mrr_pkg::kind_t   kind;
    logic [7:0]       tx;
    logic             last;
    mrr_pkg::status_t status;
    logic [15:0]      value;
    mrr_pkg::mstate_t mstate;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  beat_t  pending_beats[$];
  reply_t replies_due[$];
  beat_t  live_beat;
  reply_t want;
  int     beats_queued = 0;
  int     accepted_beats = 0;
  int     mismatch_count = 0;
  wire    quiet = (accepted_beats >= 90) && (accepted_beats < 170);

  mrr_pkg::mstate_t mst = mrr_pkg::ST_IDLE;
  logic [8:0]  resp_len = '0;
  logic [8:0]  resp_idx = '0;
  logic [15:0] resp_crc = mrr_pkg::CRC_INIT;
  logic [7:0]  crc_lo = '0;
  logic [7:0]  val_hi = '0;
  logic [15:0] held_value = '0;

  modbus_rtu_read_register_master uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_modbus(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ data[k];
      c = c >> 1;
      if (fb) c = c ^ mrr_pkg::CRC_POLY;
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic due(input mrr_pkg::kind_t k, input logic [7:0] tx, input logic lst,
                     input mrr_pkg::status_t s, input logic [15:0] v);
    reply_t r;
    r.kind = k;
    r.tx = tx;
    r.last = lst;
    r.status = s;
    r.value = v;
    r.mstate = mst;
    replies_due.push_back(r);
  endtask

  task automatic predict_master(input beat_t b);
    int unsigned need;
    int unsigned pos;
    logic [7:0]  frame[8];
    logic [15:0] acc;
    need = 5 + 2 * b.count;
    case (b.mode)
      mrr_pkg::MODE_REQ: begin
        if (mst == mrr_pkg::ST_WAIT) begin
          due(mrr_pkg::KIND_REJECT, 8'h00, 1'b0, mrr_pkg::STAT_BUSY, 16'h0000);
        end else if (b.count == 0 || need > mrr_pkg::MAX_RESPONSE_LEN_DEF) begin
          due(mrr_pkg::KIND_REJECT, 8'h00, 1'b0, mrr_pkg::STAT_BAD_COUNT, 16'h0000);
        end else begin
          frame[0] = b.addr;
          frame[1] = mrr_pkg::FUNC_READ_HOLDING;
          frame[2] = b.first[15:8];
          frame[3] = b.first[7:0];
          frame[4] = b.count[15:8];
          frame[5] = b.count[7:0];
          acc = mrr_pkg::CRC_INIT;
          for (int k = 0; k < 6; k++) acc = crc16_modbus(acc, frame[k]);
          frame[6] = acc[7:0];
          frame[7] = acc[15:8];
          mst = mrr_pkg::ST_WAIT;
          resp_len = need[8:0];
          resp_idx = '0;
          resp_crc = mrr_pkg::CRC_INIT;
          for (int k = 0; k < 8; k++)
            due(mrr_pkg::KIND_TX, frame[k], k == 7, mrr_pkg::STAT_OK, 16'h0000);
        end
      end
      mrr_pkg::MODE_BYTE: begin
        if (mst == mrr_pkg::ST_WAIT) begin
          pos = {23'd0, resp_idx};
          resp_idx = resp_idx + 9'd1;
          if (pos + 2 < resp_len) begin
            resp_crc = crc16_modbus(resp_crc, b.rx);
            if (pos == 3) val_hi = b.rx;
            else if (pos == 4) held_value = {val_hi, b.rx};
          end else if (pos + 2 == resp_len) begin
            crc_lo = b.rx;
          end else if ({b.rx, crc_lo} == resp_crc) begin
            mst = mrr_pkg::ST_READY;
            due(mrr_pkg::KIND_VERDICT, 8'h00, 1'b0, mrr_pkg::STAT_OK, 16'h0000);
          end else begin
            mst = mrr_pkg::ST_ERROR;
            due(mrr_pkg::KIND_VERDICT, 8'h00, 1'b0, mrr_pkg::STAT_CRC_ERR, 16'h0000);
          end
        end
      end
      mrr_pkg::MODE_FETCH: begin
        if (mst == mrr_pkg::ST_READY) begin
          mst = mrr_pkg::ST_IDLE;
          due(mrr_pkg::KIND_FETCH, 8'h00, 1'b0, mrr_pkg::STAT_OK, held_value);
        end else begin
          due(mrr_pkg::KIND_FETCH, 8'h00, 1'b0, mrr_pkg::STAT_NOT_READY, 16'h0000);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_master(live_beat);
        accepted_beats <= accepted_beats + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() != 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
          live_beat = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {live_beat.rx, live_beat.count, live_beat.first, live_beat.addr};
          in_tuser <= live_beat.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing due, tdata %h", out_tdata));
        end else begin
          want = replies_due.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_tuser, want.kind));
          if (out_tdata[7:0] !== want.tx)
            report_mismatch($sformatf("tx_byte %h, want %h", out_tdata[7:0], want.tx));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last %b, want %b", out_tlast, want.last));
          if (out_tdata[10:8] !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_tdata[10:8], want.status));
          if (out_tdata[26:11] !== want.value)
            report_mismatch($sformatf("value %h, want %h", out_tdata[26:11], want.value));
          if (out_tdata[28:27] !== want.mstate)
            report_mismatch($sformatf("state %0d, want %0d", out_tdata[28:27], want.mstate));
        end
      end
      out_tready <= quiet || ($urandom_range(0, 99) >= 6);
    end
  end

  task automatic queue_beat(input logic [1:0] m, input logic [7:0] a, input logic [15:0] f,
                            input logic [15:0] c, input logic [7:0] r);
    beat_t b;
    b.mode = m;
    b.addr = a;
    b.first = f;
    b.count = c;
    b.rx = r;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_request(input logic [7:0] a, input logic [15:0] f, input logic [15:0] c);
    queue_beat(mrr_pkg::MODE_REQ, a, f, c, 8'($urandom));
  endtask

  task automatic queue_byte(input logic [7:0] r);
    queue_beat(mrr_pkg::MODE_BYTE, 8'($urandom), 16'($urandom), 16'($urandom), r);
  endtask

  task automatic queue_fetch();
    queue_beat(mrr_pkg::MODE_FETCH, 8'($urandom), 16'($urandom), 16'($urandom),
               8'($urandom));
  endtask

  task automatic queue_response(input logic [7:0] a, input int n, input bit corrupt,
                                input int keep);
    logic [7:0]  frame[$];
    logic [7:0]  octet;
    logic [15:0] acc;
    int          spot;
    frame.push_back(a);
    frame.push_back(mrr_pkg::FUNC_READ_HOLDING);
    octet = 8'(2 * n);
    frame.push_back(octet);
    repeat (2 * n) begin
      octet = 8'($urandom);
      frame.push_back(octet);
    end
    acc = mrr_pkg::CRC_INIT;
    for (int k = 0; k < frame.size(); k++) acc = crc16_modbus(acc, frame[k]);
    frame.push_back(acc[7:0]);
    frame.push_back(acc[15:8]);
    if (corrupt) begin
      spot = int'($urandom_range(0, frame.size() - 1));
      frame[spot] = frame[spot] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (int k = 0; k < keep; k++) queue_byte(frame[k]);
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_tvalid || replies_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    bit         wide_done;
    bit         paused;
    int         n;
    int         full;
    int         keep;
    logic [7:0] a;
    wide_done = 1'b0;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    queue_fetch();
    queue_byte(8'($urandom));
    queue_beat(MODE_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    queue_request(8'h00, 16'h0000, 16'd0);
    queue_request(8'hFF, 16'hFFFF, 16'd126);
    queue_request(8'hA5, 16'h1234, 16'hFFFF);
    queue_request(8'hFF, 16'hFFFF, 16'd1);
    queue_request(8'h11, 16'h0001, 16'd1);
    queue_fetch();
    queue_response(8'hFF, 1, 1'b0, 7);
    queue_byte(8'hFF);
    queue_fetch();
    queue_fetch();
    queue_request(8'h00, 16'h0000, 16'd1);
    queue_response(8'h00, 1, 1'b1, 7);
    queue_fetch();
    queue_request(8'h5A, 16'h8000, 16'd1);
    queue_response(8'h5A, 1, 1'b0, 7);
    queue_request(8'h01, 16'h7FFF, 16'd2);
    wait_drained();

    while (beats_queued < 260) begin
      if ($urandom_range(0, 99) < 80) begin
        n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 20))
                                        : int'($urandom_range(1, 4));
        if (!wide_done && beats_queued > 100) begin
          n = 60;
          wide_done = 1'b1;
        end
        a = 8'($urandom);
        full = 5 + 2 * n;
        keep = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, full - 1)) : full;
        queue_request(a, 16'($urandom), 16'(n));
        if ($urandom_range(0, 9) == 0)
          queue_request(8'($urandom), 16'($urandom), 16'($urandom_range(1, 4)));
        if ($urandom_range(0, 19) == 0) queue_fetch();
        queue_response(a, n, $urandom_range(0, 6) == 0, keep);
        if ($urandom_range(0, 4) != 0) queue_fetch();
      end else begin
        queue_beat(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom));
      end
      if (!paused && beats_queued > 180) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mrr_pkg.sv
rtl/mrr_tx.sv
rtl/mrr_ctrl.sv
rtl/modbus_rtu_read_register_master.sv
tb/tb.sv
